// ===== design/bce_pkg.sv =====
// ----------------------------------------------------------------------------
// bce_pkg
// Shared widths, constants and types of the battery charge estimator.
// ----------------------------------------------------------------------------
package bce_pkg;

    localparam int unsigned GAIN_W      = 20;
    localparam int unsigned THR_W       = 7;
    localparam int unsigned MV_W        = 16;
    localparam int unsigned PCT_W       = 7;
    localparam int unsigned GAIN_FRAC   = 16;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned APB_ADDR_W  = 3;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned CFG_IDX_W   = 1;

    // Register indexes, taken from paddr above the byte lanes.
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_GAIN     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd105625;
    localparam logic [THR_W-1:0]  THR_RESET  = 7'd20;

    // Breakpoints of the discharge curve in millivolts.
    localparam logic [MV_W-1:0] MV_PCT100 = 16'd4200;
    localparam logic [MV_W-1:0] MV_PCT80  = 16'd4000;
    localparam logic [MV_W-1:0] MV_PCT60  = 16'd3800;
    localparam logic [MV_W-1:0] MV_PCT40  = 16'd3600;
    localparam logic [MV_W-1:0] MV_PCT20  = 16'd3400;
    localparam logic [MV_W-1:0] MV_PCT0   = 16'd3000;

    localparam logic [PCT_W-1:0] PCT_100 = 7'd100;
    localparam logic [PCT_W-1:0] PCT_80  = 7'd80;
    localparam logic [PCT_W-1:0] PCT_60  = 7'd60;
    localparam logic [PCT_W-1:0] PCT_40  = 7'd40;
    localparam logic [PCT_W-1:0] PCT_20  = 7'd20;
    localparam logic [PCT_W-1:0] PCT_0   = 7'd0;

    // floor(x / 10) == (x * 205) >> 11 for every x below 1029.
    localparam logic [7:0] DIV10_RECIP = 8'd205;
    localparam int unsigned DIV10_SHIFT = 11;

    typedef struct packed {
        logic [GAIN_W-1:0] volt_gain;
        logic [THR_W-1:0]  low_threshold;
    } cfg_t;

    // Packed so that it maps directly onto m_tdata, voltage in the low bits.
    typedef struct packed {
        logic              battery_low;
        logic [PCT_W-1:0]  percent;
        logic [MV_W-1:0]   voltage_mv;
    } result_t;

endpackage

// ===== design/bce_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bce_cfg_regs
// APB register file holding the voltage gain and the low threshold.
// ----------------------------------------------------------------------------
module bce_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bce_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [bce_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [bce_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready,
    output bce_pkg::cfg_t                        cfg
);

    logic [bce_pkg::GAIN_W-1:0]    gain_reg;
    logic [bce_pkg::THR_W-1:0]     thr_reg;
    logic [bce_pkg::CFG_IDX_W-1:0] reg_idx;
    logic                          wr_en;

    assign reg_idx = paddr[bce_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= bce_pkg::GAIN_RESET;
            thr_reg  <= bce_pkg::THR_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                bce_pkg::REG_VOLT_GAIN: begin
                    gain_reg <= pwdata[bce_pkg::GAIN_W-1:0];
                end
                bce_pkg::REG_LOW_THRESHOLD: begin
                    thr_reg <= pwdata[bce_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bce_pkg::REG_VOLT_GAIN: begin
                prdata = bce_pkg::APB_DATA_W'(gain_reg);
            end
            bce_pkg::REG_LOW_THRESHOLD: begin
                prdata = bce_pkg::APB_DATA_W'(thr_reg);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign cfg.volt_gain     = gain_reg;
    assign cfg.low_threshold = thr_reg;

endmodule

// ===== design/bce_accum.sv =====
// ----------------------------------------------------------------------------
// bce_accum
// Sums samples in groups and forms the floored group average.
// ----------------------------------------------------------------------------
module bce_accum #(
    parameter int unsigned SAMPLES_PER_READING = 8,
    parameter int unsigned ADC_WIDTH           = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ADC_WIDTH-1:0]  sample,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ADC_WIDTH-1:0]  avg
);

    localparam int unsigned LOG_S = $clog2(SAMPLES_PER_READING);
    localparam int unsigned SUM_W = ADC_WIDTH + LOG_S;
    localparam int unsigned CNT_W = (SAMPLES_PER_READING > 1) ? LOG_S : 1;
    localparam int unsigned DIV_K = SUM_W + LOG_S;
    localparam int unsigned PROD_W = 2 * SUM_W + 1;
    // Rounded-up reciprocal: (n * RECIP) >> DIV_K is exact for any n below 2**SUM_W.
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << DIV_K) + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING;
    localparam logic [SUM_W:0]     RECIP    = RECIP_FULL[SUM_W:0];
    localparam logic [CNT_W-1:0]   LAST_CNT = CNT_W'(SAMPLES_PER_READING - 1);

    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SUM_W-1:0]  tot_reg;
    logic              tot_vld_reg;
    logic [ADC_WIDTH-1:0] avg_reg;
    logic              avg_vld_reg;
    logic              last;
    logic              accept;
    logic              tot_ready;
    logic              avg_ready;
    logic [PROD_W-1:0] prod;

    assign last      = (cnt_reg == LAST_CNT);
    assign avg_ready = !avg_vld_reg || out_ready;
    assign tot_ready = !tot_vld_reg || avg_ready;
    // Samples that do not close a group only touch the accumulator.
    assign in_ready  = !last || tot_ready;
    assign accept    = in_valid && in_ready;
    assign sum_next  = sum_reg + SUM_W'(sample);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            cnt_reg     <= '0;
            tot_vld_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (last) begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end else begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            if (tot_ready) begin
                tot_vld_reg <= accept && last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tot_ready && accept && last) begin
            tot_reg <= sum_next;
        end
    end

    assign prod = PROD_W'(tot_reg) * PROD_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_vld_reg <= 1'b0;
        end else if (avg_ready) begin
            avg_vld_reg <= tot_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (avg_ready && tot_vld_reg) begin
            avg_reg <= prod[DIV_K +: ADC_WIDTH];
        end
    end

    assign out_valid = avg_vld_reg;
    assign avg       = avg_reg;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= LAST_CNT)
        else $error("sample counter ran past the group size");

    a_sum_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (sum_reg == '0))
        else $error("group sum not cleared at the start of a group");

endmodule

// ===== design/bce_scale.sv =====
// ----------------------------------------------------------------------------
// bce_scale
// Scales the average by the Q16 gain to millivolts, saturating at full scale.
// ----------------------------------------------------------------------------
module bce_scale #(
    parameter int unsigned AVG_W = 12
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [AVG_W-1:0]            avg,
    input  logic [bce_pkg::GAIN_W-1:0]  volt_gain,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bce_pkg::MV_W-1:0]    voltage_mv
);

    localparam int unsigned PROD_W = AVG_W + bce_pkg::GAIN_W;

    logic [PROD_W-1:0]            prod;
    logic [31:0]                  mv_wide;
    logic [bce_pkg::MV_W-1:0]     mv_sat;
    logic [bce_pkg::MV_W-1:0]     mv_reg;
    logic                         vld_reg;

    assign prod    = PROD_W'(avg) * PROD_W'(volt_gain);
    assign mv_wide = 32'(prod >> bce_pkg::GAIN_FRAC);
    assign mv_sat  = (|mv_wide[31:bce_pkg::MV_W]) ? '1 : mv_wide[bce_pkg::MV_W-1:0];

    assign in_ready = !vld_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            mv_reg <= mv_sat;
        end
    end

    assign out_valid  = vld_reg;
    assign voltage_mv = mv_reg;

endmodule

// ===== design/bce_curve.sv =====
// ----------------------------------------------------------------------------
// bce_curve
// Maps millivolts to charge percent on the cell curve and holds the result.
// ----------------------------------------------------------------------------
module bce_curve (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bce_pkg::MV_W-1:0]    voltage_mv,
    input  logic [bce_pkg::THR_W-1:0]   low_threshold,
    output logic                        out_valid,
    input  logic                        out_ready,
    output bce_pkg::result_t            result
);

    logic [bce_pkg::MV_W-1:0]   seg_low;
    logic [bce_pkg::PCT_W-1:0]  seg_base;
    logic                       seg_half;
    logic [bce_pkg::MV_W-1:0]   offset;
    logic [7:0]                 step_mv;
    logic [15:0]                step_prod;
    logic [bce_pkg::PCT_W-1:0]  pct;
    bce_pkg::result_t           res_c;
    bce_pkg::result_t           res_reg;
    logic                       vld_reg;

    always_comb begin
        seg_half = 1'b0;
        if (voltage_mv >= bce_pkg::MV_PCT80) begin
            seg_low  = bce_pkg::MV_PCT80;
            seg_base = bce_pkg::PCT_80;
        end else if (voltage_mv >= bce_pkg::MV_PCT60) begin
            seg_low  = bce_pkg::MV_PCT60;
            seg_base = bce_pkg::PCT_60;
        end else if (voltage_mv >= bce_pkg::MV_PCT40) begin
            seg_low  = bce_pkg::MV_PCT40;
            seg_base = bce_pkg::PCT_40;
        end else if (voltage_mv >= bce_pkg::MV_PCT20) begin
            seg_low  = bce_pkg::MV_PCT20;
            seg_base = bce_pkg::PCT_20;
        end else begin
            // The bottom segment is twice as wide, so it takes one percent per 20 mV.
            seg_low  = bce_pkg::MV_PCT0;
            seg_base = bce_pkg::PCT_0;
            seg_half = 1'b1;
        end
    end

    assign offset    = voltage_mv - seg_low;
    assign step_mv   = seg_half ? offset[8:1] : offset[7:0];
    assign step_prod = 16'(step_mv) * 16'(bce_pkg::DIV10_RECIP);

    always_comb begin
        if (voltage_mv >= bce_pkg::MV_PCT100) begin
            pct = bce_pkg::PCT_100;
        end else if (voltage_mv < bce_pkg::MV_PCT0) begin
            pct = bce_pkg::PCT_0;
        end else begin
            pct = seg_base + bce_pkg::PCT_W'(step_prod >> bce_pkg::DIV10_SHIFT);
        end
    end

    assign res_c.voltage_mv  = voltage_mv;
    assign res_c.percent     = pct;
    assign res_c.battery_low = (pct < low_threshold);

    assign in_ready = !vld_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            res_reg <= res_c;
        end
    end

    assign out_valid = vld_reg;
    assign result    = res_reg;

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg |-> (res_reg.percent <= bce_pkg::PCT_100))
        else $error("charge percent above one hundred");

    a_full_charge: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg && (res_reg.voltage_mv >= bce_pkg::MV_PCT100))
            |-> (res_reg.percent == bce_pkg::PCT_100))
        else $error("full voltage did not give full charge");

endmodule

// ===== design/battery_charge_estimator_core.sv =====
// ----------------------------------------------------------------------------
// battery_charge_estimator_core
// Averages raw ADC samples in groups and reports battery voltage and charge.
// ----------------------------------------------------------------------------
// Raw converter samples arrive on the s_ stream, one item per cycle at most.
// Every SAMPLES_PER_READING accepted samples form one group; the last sample
// of a group yields one result item on the m_ stream, earlier samples yield
// none. A result holds the battery voltage in millivolts (floored average
// times the Q16 gain on the APB port), the charge percent from the cell curve
// and a low flag against the APB threshold.
// Throughput is one sample per cycle unless a closing sample waits for a
// free stage. A result is built from the last sample of its group through
// a total register, a reciprocal-multiply average stage, a gain multiply
// stage and the output register. If m_tready stays low, results collect
// in the stages; samples that do not close a group are still taken, while
// a closing sample waits until a stage frees up. Reset empties the stages,
// clears the group sum and count and loads the default gain and threshold.
// Users must write registers only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module battery_charge_estimator_core #(
    parameter int unsigned SAMPLES_PER_READING = 8,
    parameter int unsigned ADC_WIDTH           = 12
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // s_tdata: [11:0] adc_sample, [15:12] zero
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [bce_pkg::IN_TDATA_W-1:0]        s_tdata,
    // m_tdata: [15:0] voltage_mv, [22:16] percent, [23] battery_low
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [bce_pkg::OUT_TDATA_W-1:0]       m_tdata,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bce_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [bce_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [bce_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);

    bce_pkg::cfg_t              cfg;
    bce_pkg::result_t           result;
    logic                       avg_valid;
    logic                       avg_ready;
    logic [ADC_WIDTH-1:0]       avg;
    logic                       mv_valid;
    logic                       mv_ready;
    logic [bce_pkg::MV_W-1:0]   voltage_mv;

    bce_cfg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bce_accum #(
        .SAMPLES_PER_READING (SAMPLES_PER_READING),
        .ADC_WIDTH           (ADC_WIDTH)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .sample    (s_tdata[ADC_WIDTH-1:0]),
        .out_valid (avg_valid),
        .out_ready (avg_ready),
        .avg       (avg)
    );

    bce_scale #(
        .AVG_W (ADC_WIDTH)
    ) u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (avg_valid),
        .in_ready   (avg_ready),
        .avg        (avg),
        .volt_gain  (cfg.volt_gain),
        .out_valid  (mv_valid),
        .out_ready  (mv_ready),
        .voltage_mv (voltage_mv)
    );

    bce_curve u_curve (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (mv_valid),
        .in_ready      (mv_ready),
        .voltage_mv    (voltage_mv),
        .low_threshold (cfg.low_threshold),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .result        (result)
    );

    assign m_tdata = result;

endmodule
